[design/mel_pkg.sv]
// ----------------------------------------------------------------------------
// mel_pkg
// Shared types and constants of the motion event ring log.
// ----------------------------------------------------------------------------
package mel_pkg;

  // Field widths
  localparam int unsigned NOW_W     = 64;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned TIME_MS_W = 55;
  localparam int unsigned WIN_W     = 32;
  localparam int unsigned MAXC_W    = 16;
  localparam int unsigned CNT_OUT_W = 5;

  // Reset value of the motion window, microseconds
  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd30000000;

  // Divide by 1000, four quotient bits per step
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned DIV_DIGIT_W = 4;
  localparam int unsigned DIV_STEPS   = NOW_W / DIV_DIGIT_W;
  localparam int unsigned DIV_STEP_W  = $clog2(DIV_STEPS);
  localparam int unsigned DIV_REM_W   = 10;
  localparam int unsigned DIV_PART_W  = DIV_REM_W + DIV_DIGIT_W;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_MOTION = 2'd0,
    KIND_LOG    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } mel_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SINGLE,
    ST_RADDR,
    ST_RDATA
  } mel_state_e;

  // One ring entry
  typedef struct packed {
    logic [TIME_MS_W-1:0] time_ms;
    logic [DUR_W-1:0]     dur_ms;
  } mel_entry_t;

endpackage

[design/motion_event_ring_log.sv]
// ----------------------------------------------------------------------------
// motion_event_ring_log
// Motion window detector with an overwriting ring of logged events.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A motion edge, clear or empty read
// passes through ST_EXEC and ST_SINGLE to its result word; a log event adds
// the 16-step divide of the time by 1000 and the handoff of its quotient;
// a read streams its entries, one entry a cycle from the ring memory through
// its registered read port, as long as the output is not stalled. A result
// word sits in an output register until it is taken, and the next word is
// accepted while it waits there.
// ----------------------------------------------------------------------------
module motion_event_ring_log
  import mel_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration
  input  logic                 cfg_we_i,
  input  logic [WIN_W-1:0]     cfg_wdata_i,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [NOW_W-1:0]     now_us_i,
  input  logic [DUR_W-1:0]     dur_ms_i,
  input  logic [MAXC_W-1:0]    max_count_i,
  // Output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 motion_detected_o,
  output logic [CNT_OUT_W-1:0] stored_count_o,
  output logic                 entry_valid_o,
  output logic [TIME_MS_W-1:0] entry_time_ms_o,
  output logic [DUR_W-1:0]     entry_dur_ms_o,
  output logic                 last_result_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  mel_state_e           state_q, state_d;
  logic [WIN_W-1:0]     window_q;
  logic [NOW_W-1:0]     last_motion_q, last_motion_d;
  logic [AW-1:0]        slot_q, slot_d;
  logic [CW-1:0]        fill_q, fill_d;
  logic                 motion_q, motion_d;
  logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        rd_left_q, rd_left_d;

  // Captured input word
  mel_kind_e            kind_q;
  logic [NOW_W-1:0]     now_q;
  logic [DUR_W-1:0]     dur_q;
  logic [MAXC_W-1:0]    maxc_q;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_motion_q, out_motion_d;
  logic [CNT_OUT_W-1:0] out_count_q, out_count_d;
  logic                 out_evalid_q, out_evalid_d;
  logic [TIME_MS_W-1:0] out_time_q, out_time_d;
  logic [DUR_W-1:0]     out_dur_q, out_dur_d;
  logic                 out_last_q, out_last_d;

  logic                 in_accept;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic [TIME_MS_W-1:0] div_quo;
  logic                 wr_en;
  mel_entry_t           wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        rd_ptr_inc;
  logic [AW-1:0]        slot_inc;
  mel_entry_t           rd_data;
  logic [NOW_W-1:0]     last_eff;
  logic [NOW_W-1:0]     age;
  logic [SW-1:0]        start_sum;
  logic [AW-1:0]        start_slot;
  logic [CW-1:0]        count;

  // Divider and ring memory
  mel_div1000 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (now_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  mel_ring_mem #(
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_q),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wr_data.time_ms = div_quo;
  assign wr_data.dur_ms  = dur_q;

  // Wrap ring pointers
  assign rd_ptr_inc = (rd_ptr_q == AW'(LOG_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign slot_inc   = (slot_q == AW'(LOG_DEPTH - 1)) ? '0 : slot_q + 1'b1;

  // Judge motion against the updated last motion time
  assign last_eff = (kind_q == KIND_MOTION) ? now_q : last_motion_q;
  assign age      = now_q - last_eff;

  // Locate the oldest entry and the read length
  assign start_sum  = SW'(slot_q) + SW'(LOG_DEPTH) - SW'(fill_q);
  assign start_slot = (start_sum >= SW'(LOG_DEPTH)) ? AW'(start_sum - SW'(LOG_DEPTH))
                                                    : AW'(start_sum);
  assign count      = (MAXC_W'(fill_q) < maxc_q) ? fill_q : CW'(maxc_q);

  // Sequence one word
  always_comb begin
    state_d       = state_q;
    last_motion_d = last_motion_q;
    slot_d        = slot_q;
    fill_d        = fill_q;
    motion_d      = motion_q;
    rd_ptr_d      = rd_ptr_q;
    rd_left_d     = rd_left_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_motion_d  = out_motion_q;
    out_count_d   = out_count_q;
    out_evalid_d  = out_evalid_q;
    out_time_d    = out_time_q;
    out_dur_d     = out_dur_q;
    out_last_d    = out_last_q;
    div_start     = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rd_ptr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        motion_d = (last_eff != '0) && (age < NOW_W'(window_q));
        unique case (kind_q)
          KIND_MOTION: begin
            last_motion_d = now_q;
            state_d       = ST_SINGLE;
          end
          KIND_LOG: begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
          KIND_READ: begin
            rd_ptr_d  = start_slot;
            rd_left_d = count;
            state_d   = (count == '0) ? ST_SINGLE : ST_RADDR;
          end
          KIND_CLEAR: begin
            slot_d  = '0;
            fill_d  = '0;
            state_d = ST_SINGLE;
          end
          default: state_d = ST_SINGLE;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          wr_en   = 1'b1;
          slot_d  = slot_inc;
          if (fill_q < CW'(LOG_DEPTH)) begin
            fill_d = fill_q + 1'b1;
          end
          state_d = ST_SINGLE;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_motion_d = motion_q;
          out_count_d  = CNT_OUT_W'(fill_q);
          out_evalid_d = 1'b0;
          out_time_d   = '0;
          out_dur_d    = '0;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_RADDR: begin
        rd_en   = 1'b1;
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_motion_d = motion_q;
          out_count_d  = CNT_OUT_W'(fill_q);
          out_evalid_d = 1'b1;
          out_time_d   = rd_data.time_ms;
          out_dur_d    = rd_data.dur_ms;
          out_last_d   = (rd_left_q == CW'(1));
          rd_left_d    = rd_left_q - 1'b1;
          rd_ptr_d     = rd_ptr_inc;
          if (rd_left_q == CW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_ptr_inc;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      window_q      <= WINDOW_RESET;
      last_motion_q <= '0;
      slot_q        <= '0;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      last_motion_q <= last_motion_d;
      slot_q        <= slot_d;
      fill_q        <= fill_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= mel_kind_e'(kind_i);
      now_q  <= now_us_i;
      dur_q  <= dur_ms_i;
      maxc_q <= max_count_i;
    end
    motion_q     <= motion_d;
    rd_ptr_q     <= rd_ptr_d;
    rd_left_q    <= rd_left_d;
    out_motion_q <= out_motion_d;
    out_count_q  <= out_count_d;
    out_evalid_q <= out_evalid_d;
    out_time_q   <= out_time_d;
    out_dur_q    <= out_dur_d;
    out_last_q   <= out_last_d;
  end

  // Drive outputs
  assign out_valid_o       = out_valid_q;
  assign motion_detected_o = out_motion_q;
  assign stored_count_o    = out_count_q;
  assign entry_valid_o     = out_evalid_q;
  assign entry_time_ms_o   = out_time_q;
  assign entry_dur_ms_o    = out_dur_q;
  assign last_result_o     = out_last_q;

endmodule

[design/mel_ring_mem.sv]
// ----------------------------------------------------------------------------
// mel_ring_mem
// Ring entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mel_ring_mem
  import mel_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  mel_entry_t    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output mel_entry_t    rd_data_o
);

  mel_entry_t mem_q [DEPTH];
  mel_entry_t rd_data_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read entry, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/mel_div1000.sv]
// ----------------------------------------------------------------------------
// mel_div1000
// Iterative divide of a microsecond time by 1000, one radix-16 digit a cycle.
// ----------------------------------------------------------------------------
module mel_div1000
  import mel_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NOW_W-1:0]     dividend_i,
  output logic                 done_o,
  output logic [TIME_MS_W-1:0] quotient_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_STEP_W-1:0] step_q, step_d;
  logic [NOW_W-1:0]      num_q, num_d;
  logic [DIV_REM_W-1:0]  rem_q, rem_d;
  logic [TIME_MS_W-1:0]  quo_q, quo_d;

  logic [DIV_PART_W-1:0]  part;
  logic [DIV_PART_W-1:0]  sub;
  logic [DIV_DIGIT_W-1:0] digit;

  // Pick the quotient digit against the multiples of 1000
  always_comb begin
    part  = {rem_q, num_q[NOW_W-1 -: DIV_DIGIT_W]};
    digit = '0;
    sub   = '0;
    for (int k = 1; k < (1 << DIV_DIGIT_W); k++) begin
      if (part >= DIV_PART_W'(k * US_PER_MS)) begin
        digit = DIV_DIGIT_W'(k);
        sub   = DIV_PART_W'(k * US_PER_MS);
      end
    end
  end

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d  = {num_q[NOW_W-DIV_DIGIT_W-1:0], {DIV_DIGIT_W{1'b0}}};
      rem_d  = DIV_REM_W'(part - sub);
      quo_d  = {quo_q[TIME_MS_W-DIV_DIGIT_W-1:0], digit};
      step_d = step_q + 1'b1;
      if (step_q == DIV_STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[tb/tb_motion_event_ring_log.sv]
// ----------------------------------------------------------------------------
// tb_motion_event_ring_log
// Self-checking bench for the motion window detector and its event ring.
// ----------------------------------------------------------------------------
// A mirror of the block keeps its own last motion time, ring and fill count,
// and queues the result words that each accepted input word must produce.
// Every result word taken from the block is compared field by field with the
// oldest queued word. A directed run covers empty reads, zero and maximal
// fields, the window boundary, motion at time zero and time wrap. Random
// phases follow, each under its own motion window, with random gaps on the
// input side, save in one phase without gaps, and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_motion_event_ring_log;
  import mel_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int PHASE_WORDS = 52;
  localparam int SETTLE_CYC  = 30;
  localparam int QUIET_LIMIT = 3000;

  // One result word as the block presents it
  typedef struct packed {
    logic                 motion;
    logic [CNT_OUT_W-1:0] count;
    logic                 valid;
    logic [TIME_MS_W-1:0] time_ms;
    logic [DUR_W-1:0]     dur_ms;
    logic                 last_word;
  } log_word_t;

  // Mirror of the block state and the words it still owes
  class event_log_mirror;
    logic [WIN_W-1:0]     window_us;
    logic [NOW_W-1:0]     last_motion_us;
    logic [TIME_MS_W-1:0] ring_ms [RING_DEPTH];
    logic [DUR_W-1:0]     ring_dur [RING_DEPTH];
    int                   wr_slot;
    int                   fill;
    log_word_t            owed_words [$];
    int                   mismatch_count;

    function new();
      window_us      = WINDOW_RESET;
      last_motion_us = '0;
      wr_slot        = 0;
      fill           = 0;
      mismatch_count = 0;
      foreach (ring_ms[i]) begin
        ring_ms[i]  = '0;
        ring_dur[i] = '0;
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    // Update state for one accepted word and queue the words it owes
    function void take_word(mel_kind_e kind, logic [NOW_W-1:0] now_us,
                            logic [DUR_W-1:0] dur_ms, logic [MAXC_W-1:0] maxc);
      logic [NOW_W-1:0] age_us;
      logic             motion;
      int               n;
      int               first;
      log_word_t        w;
      case (kind)
        KIND_MOTION: last_motion_us = now_us;
        KIND_LOG: begin
          ring_ms[wr_slot]  = TIME_MS_W'(now_us / NOW_W'(US_PER_MS));
          ring_dur[wr_slot] = dur_ms;
          wr_slot = (wr_slot + 1) % RING_DEPTH;
          if (fill < RING_DEPTH) fill++;
        end
        KIND_CLEAR: begin
          foreach (ring_ms[i]) begin
            ring_ms[i]  = '0;
            ring_dur[i] = '0;
          end
          wr_slot = 0;
          fill    = 0;
        end
        default: ;
      endcase
      age_us = now_us - last_motion_us;
      motion = (last_motion_us != '0) && (age_us < NOW_W'(window_us));
      n = 0;
      if (kind == KIND_READ) n = (int'(maxc) < fill) ? int'(maxc) : fill;
      w = '0;
      w.motion = motion;
      w.count  = CNT_OUT_W'(fill);
      if (n == 0) begin
        w.last_word = 1'b1;
        owed_words.push_back(w);
      end else begin
        first = (wr_slot + RING_DEPTH - fill) % RING_DEPTH;
        for (int i = 0; i < n; i++) begin
          w.valid     = 1'b1;
          w.time_ms   = ring_ms[(first + i) % RING_DEPTH];
          w.dur_ms    = ring_dur[(first + i) % RING_DEPTH];
          w.last_word = (i == n - 1);
          owed_words.push_back(w);
        end
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    // Compare one taken word with the oldest owed word
    function void compare_word(log_word_t got);
      log_word_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = owed_words.pop_front();
        check_field("motion_detected", 64'(want.motion), 64'(got.motion));
        check_field("stored_count", 64'(want.count), 64'(got.count));
        check_field("entry_valid", 64'(want.valid), 64'(got.valid));
        check_field("entry_time_ms", 64'(want.time_ms), 64'(got.time_ms));
        check_field("entry_dur_ms", 64'(want.dur_ms), 64'(got.dur_ms));
        check_field("last_result", 64'(want.last_word), 64'(got.last_word));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [WIN_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           kind_i;
  logic [NOW_W-1:0]     now_us_i;
  logic [DUR_W-1:0]     dur_ms_i;
  logic [MAXC_W-1:0]    max_count_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 motion_detected_o;
  logic [CNT_OUT_W-1:0] stored_count_o;
  logic                 entry_valid_o;
  logic [TIME_MS_W-1:0] entry_time_ms_o;
  logic [DUR_W-1:0]     entry_dur_ms_o;
  logic                 last_result_o;

  event_log_mirror  mirror;
  logic [NOW_W-1:0] now_cursor;
  logic [NOW_W-1:0] edge_us;
  bit               no_gaps;

  motion_event_ring_log #(
    .LOG_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .now_us_i           (now_us_i),
    .dur_ms_i           (dur_ms_i),
    .max_count_i        (max_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .motion_detected_o  (motion_detected_o),
    .stored_count_o     (stored_count_o),
    .entry_valid_o      (entry_valid_o),
    .entry_time_ms_o    (entry_time_ms_o),
    .entry_dur_ms_o     (entry_dur_ms_o),
    .last_result_o      (last_result_o)
  );

  // Toggle the clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one input word and hold it until the block takes it
  task automatic send_word(mel_kind_e kind, logic [NOW_W-1:0] now_us,
                           logic [DUR_W-1:0] dur_ms, logic [MAXC_W-1:0] maxc);
    int gap;
    bit stalled;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    now_us_i    <= now_us;
    dur_ms_i    <= dur_ms;
    max_count_i <= maxc;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      if (!stalled) mirror.take_word(kind, now_us, dur_ms, maxc);
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Hold off input until every owed word has come and the block settles
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write the motion window while the block is idle
  task automatic set_window(logic [WIN_W-1:0] value);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    mirror.window_us = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random word; times favor the window boundary and the 64-bit wrap
  task automatic random_word();
    int               r;
    mel_kind_e        kind;
    logic [NOW_W-1:0] t;
    logic [MAXC_W-1:0] maxc;
    r = $urandom_range(0, 99);
    if (r < 22)      kind = KIND_MOTION;
    else if (r < 58) kind = KIND_LOG;
    else if (r < 97) kind = KIND_READ;
    else             kind = KIND_CLEAR;
    r = $urandom_range(0, 99);
    if (r < 40)      now_cursor = now_cursor + NOW_W'($urandom_range(0, 2000));
    else if (r < 65) now_cursor = edge_us + NOW_W'(mirror.window_us) - 1
                                  + NOW_W'($urandom_range(0, 2));
    else if (r < 80) now_cursor = now_cursor + NOW_W'($urandom);
    else if (r < 88) now_cursor = '1 - NOW_W'($urandom_range(0, 3000));
    else if (r < 95) now_cursor = {$urandom, $urandom};
    t = now_cursor;
    if (kind == KIND_MOTION) begin
      if ($urandom_range(0, 19) == 0) t = '0;
      edge_us = t;
    end
    r = $urandom_range(0, 99);
    if (r < 70)      maxc = MAXC_W'($urandom_range(0, 18));
    else if (r < 85) maxc = '1;
    else             maxc = MAXC_W'($urandom);
    send_word(kind, t, $urandom, maxc);
  endtask

  // Stall the output at random, with calm stretches in between
  initial begin
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 40)) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Check every word the block hands over
  always @(negedge clk_i) begin
    log_word_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got.motion    = motion_detected_o;
      got.count     = stored_count_o;
      got.valid     = entry_valid_o;
      got.time_ms   = entry_time_ms_o;
      got.dur_ms    = entry_dur_ms_o;
      got.last_word = last_result_o;
      mirror.compare_word(got);
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[motion_event_ring_log] ERROR");
    $finish;
  end

  initial begin
    logic [WIN_W-1:0] windows [6];
    mirror      = new();
    no_gaps     = 1'b0;
    now_cursor  = '0;
    edge_us     = '0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    kind_i      <= KIND_MOTION;
    now_us_i    <= '0;
    dur_ms_i    <= '0;
    max_count_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty log, zero time, field extremes, window edge, wrap
    send_word(KIND_READ, 64'd5, '0, 16'd16);
    send_word(KIND_MOTION, '0, '0, '0);
    send_word(KIND_CLEAR, 64'd7, '1, '1);
    send_word(KIND_LOG, '0, '0, '0);
    send_word(KIND_LOG, '1, '1, '1);
    send_word(KIND_READ, 64'd100, '0, '0);
    send_word(KIND_READ, 64'd200, '0, '1);
    send_word(KIND_READ, 64'd300, '0, 16'd1);
    send_word(KIND_MOTION, 64'd1000, 32'h5555_5555, 16'hAAAA);
    send_word(KIND_LOG, 64'd1000 + 64'd29_999_999, 32'hAAAA_AAAA, 16'h5555);
    send_word(KIND_READ, 64'd1000 + 64'd30_000_000, '0, 16'd2);
    send_word(KIND_MOTION, 64'hFFFF_FFFF_FFFF_FF00, '0, '0);
    send_word(KIND_LOG, 64'h10, 32'd12345, '0);
    send_word(KIND_READ, 64'h20, '0, 16'd16);
    send_word(KIND_CLEAR, 64'h30, '0, '0);
    send_word(KIND_READ, 64'h40, '0, 16'd16);
    send_word(KIND_LOG, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0001, '0);
    send_word(KIND_READ, 64'h5555_5555_5555_5555, '0, 16'd17);

    // Random phases, each under its own window, extremes included
    windows[0] = '0;
    windows[1] = '1;
    windows[2] = 32'd1;
    windows[3] = 32'd5000;
    windows[4] = 32'd2_000_000;
    windows[5] = $urandom;
    for (int p = 0; p < 6; p++) begin
      set_window(windows[p]);
      no_gaps = (p == 3);
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
    end
    no_gaps = 1'b0;

    drain_block();
    if (mirror.mismatch_count == 0 && mirror.pending() == 0) begin
      $display("[motion_event_ring_log] OK");
    end else begin
      $display("[motion_event_ring_log] ERROR");
    end
    $finish;
  end

endmodule
